>>> hw/rtl/mrsrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrsrb_pkg
// Shared widths, codes and helper functions of the segmented ring buffer.
// ----------------------------------------------------------------------------
package mrsrb_pkg;

    localparam int NUM_SEGS    = 16;
    localparam int NUM_LINES   = 64;
    localparam int NUM_READERS = 4;
    localparam int BYTES_MAX   = 8;

    localparam int SEG_W  = $clog2(NUM_SEGS);
    localparam int LINE_W = $clog2(NUM_LINES);
    localparam int RD_W   = $clog2(NUM_READERS);

    // Configuration register indexes.
    localparam logic [2:0] CFG_LINES     = 3'd0;
    localparam logic [2:0] CFG_BYTES     = 3'd1;
    localparam logic [2:0] CFG_OVERWRITE = 3'd2;
    localparam logic [2:0] CFG_READERS   = 3'd3;
    localparam logic [2:0] CFG_SEGMENTS  = 3'd4;

    // Operation codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RANGE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ARG  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Keeps the low n bytes of a line.
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            m[b*8 +: 8] = (4'(b) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    // Ring pointer advance with wrap at the last line in use.
    function automatic logic [LINE_W-1:0] next_ptr(input logic [LINE_W-1:0] p,
                                                   input logic [6:0] lines);
        logic [LINE_W-1:0] r;
        if ({1'b0, p} >= (lines - 7'd1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/mrsrb_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrsrb_line_mem
// Single-port line store with a registered read, one word per line.
// ----------------------------------------------------------------------------
module mrsrb_line_mem
    import mrsrb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [SEG_W+LINE_W-1:0]   i_addr,
    input  logic [63:0]               i_wdata,
    output logic [63:0]               o_rdata
);

    logic [63:0] r_mem [NUM_SEGS*NUM_LINES];
    logic [63:0] r_rdata;

    // Write or read one line per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mrsrb_ptr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrsrb_ptr_mem
// Per segment and reader read pointers; entries never written read as zero.
// ----------------------------------------------------------------------------
module mrsrb_ptr_mem
    import mrsrb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [SEG_W+RD_W-1:0]   i_addr,
    input  logic [LINE_W-1:0]       i_wdata,
    output logic [LINE_W-1:0]       o_rdata
);

    logic [LINE_W-1:0]             r_mem [NUM_SEGS*NUM_READERS];
    logic [NUM_SEGS*NUM_READERS-1:0] r_valid;
    logic [LINE_W-1:0]             r_rdata;
    logic                          r_rvalid;

    // Storage with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    // Valid bits stand in for the zero reset of the pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_addr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_addr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

>>> hw/rtl/multi_reader_segmented_ring_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_reader_segmented_ring_buffer_top
// Segmented ring buffer with one writer and several readers.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time and returns exactly one result
// for each. A write checks the read pointer of each active reader for
// fullness, one reader at a time, unless overwrite is enabled. A ranged read
// visits segments in turn, first inside the range and then, with stealing,
// outside it, until one holds data. The read pointer memory has a registered
// read and is walked one entry per step. A finished result waits in the
// output register while the next input transaction is taken. The
// configuration port is always ready.
module multi_reader_segmented_ring_buffer_top
    import mrsrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_segment,
    input  logic [1:0]  i_reader,
    input  logic [63:0] i_line_data,
    input  logic [3:0]  i_write_bytes,
    input  logic [3:0]  i_buffer_bytes,
    input  logic [4:0]  i_range_low,
    input  logic [4:0]  i_range_high,
    input  logic        i_steal_enable,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_byte_count,
    output logic [63:0] o_read_data,
    output logic [3:0]  o_served_segment,
    output logic        o_stolen
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DEC   = 11'b00000000010,
        S_WCHK  = 11'b00000000100,
        S_WCMP  = 11'b00000001000,
        S_WRITE = 11'b00000010000,
        S_RNG   = 11'b00000100000,
        S_STL   = 11'b00001000000,
        S_VRD   = 11'b00010000000,
        S_VCHK  = 11'b00100000000,
        S_VLN   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    typedef enum logic [1:0] {
        RET_DONE = 2'd0,
        RET_RNG  = 2'd1,
        RET_STL  = 2'd2
    } t_ret;

    t_state r_state;

    // Configuration registers.
    logic [6:0] r_cfg_lines;
    logic [3:0] r_cfg_bytes;
    logic       r_cfg_ovw;
    logic [2:0] r_cfg_readers;
    logic [4:0] r_cfg_segs;

    // Latched transaction.
    logic [1:0]  r_op;
    logic [1:0]  r_rd;
    logic [63:0] r_data;
    logic [3:0]  r_wbytes;
    logic [3:0]  r_buf;
    logic [4:0]  r_lo;
    logic [4:0]  r_hi;
    logic        r_steal;

    // Sequencer state.
    logic [SEG_W-1:0]  r_cur;
    logic [4:0]        r_idx;
    logic [LINE_W-1:0] r_np;
    logic [3:0]        r_n;
    logic              r_is_stolen;
    t_ret              r_ret;

    // Pointer registers.
    logic [LINE_W-1:0] r_wp [NUM_SEGS];
    logic [4:0]        r_rpp [NUM_READERS];
    logic [4:0]        r_spp [NUM_READERS];

    // Pending and output results.
    logic [1:0]  r_res_status;
    logic [3:0]  r_res_count;
    logic [63:0] r_res_data;
    logic [3:0]  r_res_served;
    logic        r_res_stolen;
    logic        r_o_valid;
    logic [1:0]  r_o_status;
    logic [3:0]  r_o_count;
    logic [63:0] r_o_data;
    logic [3:0]  r_o_served;
    logic        r_o_stolen;

    // Clamped configuration.
    logic [6:0] eff_lines;
    logic [3:0] eff_bytes;
    logic [2:0] eff_readers;
    logic [4:0] eff_segs;

    always_comb begin
        eff_lines   = (r_cfg_lines == 7'd0) ? 7'd1 :
                      (r_cfg_lines > 7'(NUM_LINES)) ? 7'(NUM_LINES) : r_cfg_lines;
        eff_bytes   = (r_cfg_bytes == 4'd0) ? 4'd1 :
                      (r_cfg_bytes > 4'(BYTES_MAX)) ? 4'(BYTES_MAX) : r_cfg_bytes;
        eff_readers = (r_cfg_readers == 3'd0) ? 3'd1 :
                      (r_cfg_readers > 3'(NUM_READERS)) ? 3'(NUM_READERS) : r_cfg_readers;
        eff_segs    = (r_cfg_segs == 5'd0) ? 5'd1 :
                      (r_cfg_segs > 5'(NUM_SEGS)) ? 5'(NUM_SEGS) : r_cfg_segs;
    end

    // Memories.
    logic                     ptr_we;
    logic [SEG_W+RD_W-1:0]    ptr_addr;
    logic [LINE_W-1:0]        ptr_wdata;
    logic [LINE_W-1:0]        ptr_rdata;
    logic                     line_we;
    logic [SEG_W+LINE_W-1:0]  line_addr;
    logic [63:0]              line_wdata;
    logic [63:0]              line_rdata;

    mrsrb_ptr_mem u_ptr_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ptr_we),
        .i_addr  (ptr_addr),
        .i_wdata (ptr_wdata),
        .o_rdata (ptr_rdata)
    );

    mrsrb_line_mem u_line_mem (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_addr  (line_addr),
        .i_wdata (line_wdata),
        .o_rdata (line_rdata)
    );

    logic [LINE_W-1:0] wp_cur;
    logic [4:0]        rng;
    logic [4:0]        srng;
    logic [4:0]        rpp_cur;
    logic [4:0]        spp_cur;
    logic [4:0]        rng_seg;
    logic [4:0]        stl_a;
    logic [4:0]        stl_seg;
    logic              visit_empty;
    logic [3:0]        read_n;

    assign wp_cur  = r_wp[r_cur];
    assign rng     = r_hi - r_lo;
    assign srng    = eff_segs - rng;
    assign rpp_cur = r_rpp[r_rd];
    assign spp_cur = r_spp[r_rd];

    // Stale round-robin pointers restart inside or outside the range.
    always_comb begin
        rng_seg = (rpp_cur >= r_hi || rpp_cur < r_lo) ? r_lo : rpp_cur;
        stl_a   = (spp_cur >= eff_segs) ? ((r_lo == 5'd0) ? r_hi : 5'd0) : spp_cur;
        stl_seg = (stl_a >= r_lo && stl_a < r_hi) ?
                  ((r_hi == eff_segs) ? 5'd0 : r_hi) : stl_a;
    end

    assign visit_empty = (r_buf == 4'd0) || (ptr_rdata == wp_cur);
    assign read_n      = (r_buf < eff_bytes) ? r_buf : eff_bytes;

    // Memory port control.
    always_comb begin
        ptr_we     = 1'b0;
        ptr_addr   = {r_cur, r_rd};
        ptr_wdata  = next_ptr(ptr_rdata, eff_lines);
        line_we    = 1'b0;
        line_addr  = {r_cur, ptr_rdata};
        line_wdata = r_data & byte_mask(r_wbytes);
        if (r_state == S_WCHK) begin
            ptr_addr = {r_cur, r_idx[RD_W-1:0]};
        end
        if (r_state == S_VCHK && !visit_empty) begin
            ptr_we = 1'b1;
        end
        if (r_state == S_WRITE) begin
            line_we   = 1'b1;
            line_addr = {r_cur, wp_cur};
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lines   <= 7'(NUM_LINES);
            r_cfg_bytes   <= 4'(BYTES_MAX);
            r_cfg_ovw     <= 1'b0;
            r_cfg_readers <= 3'd1;
            r_cfg_segs    <= 5'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINES:     r_cfg_lines   <= i_cfg_data;
                CFG_BYTES:     r_cfg_bytes   <= i_cfg_data[3:0];
                CFG_OVERWRITE: r_cfg_ovw     <= i_cfg_data[0];
                CFG_READERS:   r_cfg_readers <= i_cfg_data[2:0];
                CFG_SEGMENTS:  r_cfg_segs    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            for (int k = 0; k < NUM_SEGS; k++) begin
                r_wp[k] <= '0;
            end
            for (int k = 0; k < NUM_READERS; k++) begin
                r_rpp[k] <= '0;
                r_spp[k] <= '0;
            end
        end else begin
            // The done state reloads the output register itself.
            if (r_o_valid && !i_stall && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op         <= i_op;
                        r_cur        <= i_segment;
                        r_rd         <= i_reader;
                        r_data       <= i_line_data;
                        r_wbytes     <= i_write_bytes;
                        r_buf        <= i_buffer_bytes;
                        r_lo         <= i_range_low;
                        r_hi         <= i_range_high;
                        r_steal      <= i_steal_enable;
                        r_res_status <= ST_OK;
                        r_res_count  <= '0;
                        r_res_data   <= '0;
                        r_res_served <= '0;
                        r_res_stolen <= 1'b0;
                        r_is_stolen  <= 1'b0;
                        r_ret        <= RET_DONE;
                        r_idx        <= '0;
                        r_state      <= S_DEC;
                    end
                end
                S_DEC: begin
                    priority if (r_op == OP_WRITE) begin
                        if ({1'b0, r_cur} >= eff_segs || r_wbytes > eff_bytes) begin
                            r_res_status <= ST_ARG;
                            r_state      <= S_DONE;
                        end else if (r_wbytes == 4'd0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_np    <= next_ptr(wp_cur, eff_lines);
                            r_state <= r_cfg_ovw ? S_WRITE : S_WCHK;
                        end
                    end else if (r_op == OP_READ) begin
                        if ({1'b0, r_cur} >= eff_segs || {1'b0, r_rd} >= eff_readers) begin
                            r_res_status <= ST_ARG;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_VRD;
                        end
                    end else if (r_op == OP_RANGE) begin
                        if ({1'b0, r_rd} >= eff_readers || r_lo > r_hi || r_hi > eff_segs) begin
                            r_res_status <= ST_ARG;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_RNG;
                        end
                    end else begin
                        r_res_status <= ST_ARG;
                        r_state      <= S_DONE;
                    end
                end
                // Full check: one reader pointer per pass.
                S_WCHK: begin
                    if (r_idx < {2'b00, eff_readers}) begin
                        r_state <= S_WCMP;
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_WCMP: begin
                    if (ptr_rdata == r_np) begin
                        r_res_status <= ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 5'd1;
                        r_state <= S_WCHK;
                    end
                end
                S_WRITE: begin
                    r_wp[r_cur] <= r_np;
                    r_res_count <= eff_bytes;
                    r_state     <= S_DONE;
                end
                // Round robin over the requested range.
                S_RNG: begin
                    if (r_idx < rng) begin
                        r_rpp[r_rd] <= rng_seg + 5'd1;
                        r_cur       <= rng_seg[SEG_W-1:0];
                        r_idx       <= r_idx + 5'd1;
                        r_ret       <= RET_RNG;
                        r_state     <= S_VRD;
                    end else if (r_steal) begin
                        r_idx   <= '0;
                        r_state <= S_STL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                // Steal from the segments outside the range.
                S_STL: begin
                    if (r_idx < srng) begin
                        r_spp[r_rd] <= stl_seg + 5'd1;
                        r_idx       <= r_idx + 5'd1;
                        if (stl_seg < eff_segs) begin
                            r_cur       <= stl_seg[SEG_W-1:0];
                            r_ret       <= RET_STL;
                            r_is_stolen <= 1'b1;
                            r_state     <= S_VRD;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_VRD: begin
                    r_state <= S_VCHK;
                end
                S_VCHK: begin
                    if (visit_empty) begin
                        unique case (r_ret)
                            RET_RNG:  r_state <= S_RNG;
                            RET_STL:  r_state <= S_STL;
                            default:  r_state <= S_DONE;
                        endcase
                    end else begin
                        r_n     <= read_n;
                        r_state <= S_VLN;
                    end
                end
                S_VLN: begin
                    r_res_count  <= r_n;
                    r_res_data   <= line_rdata & byte_mask(r_n);
                    r_res_served <= r_cur;
                    r_res_stolen <= r_is_stolen;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_o_valid || !i_stall)) begin
            r_o_status <= r_res_status;
            r_o_count  <= r_res_count;
            r_o_data   <= r_res_data;
            r_o_served <= r_res_served;
            r_o_stolen <= r_res_stolen;
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_byte_count     = r_o_count;
    assign o_read_data      = r_o_data;
    assign o_served_segment = r_o_served;
    assign o_stolen         = r_o_stolen;

endmodule
